[rtl/tmh_pkg.sv]
`timescale 1ns / 1ps
package tmh_pkg;
   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_POP    = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic       KIND_UPDATE = 1'b0;
   localparam logic       KIND_FINAL  = 1'b1;
   localparam logic [31:0] TIMEOUT_EMPTY = 32'hFFFF_FFFF;
   localparam logic [31:0] TIMEOUT_MAX   = 32'h7FFF_FFFF;
endpackage

[rtl/timer_min_heap.sv]
`timescale 1ns / 1ps
// Binary min-heap timer queue of (deadline, handle) entries held in one two-read-port,
// one-write-port synchronous RAM. Each operation walks the heap one level per step; a
// step is a read state then a compare state, and each entry that moves sends one
// update word on the result channel. The compare states and the word loads wait while
// the output register is held; every operation ends with one final word (last = 1).
// The next operation is taken once the final word has been moved to the output
// register.
module timer_min_heap #(
   parameter int HEAP_DEPTH   = 256,
   parameter int HANDLE_COUNT = 1024,
   parameter int TIME_BITS    = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic [TIME_BITS-1:0]                req_deadline,
   input  logic [$clog2(HANDLE_COUNT)-1:0]     req_handle,
   input  logic [$clog2(HEAP_DEPTH+1)-1:0]     req_position_id,
   input  logic [TIME_BITS-1:0]                req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [$clog2(HANDLE_COUNT)-1:0]     rsp_owner,
   output logic [$clog2(HEAP_DEPTH+1)-1:0]     rsp_new_position,
   output logic                                rsp_popped_valid,
   output logic                                rsp_overflow,
   output logic [$clog2(HEAP_DEPTH+1)-1:0]     rsp_entry_count,
   output logic signed [31:0]                  rsp_time_left,
   output logic                                rsp_last
);
   import tmh_pkg::*;

   localparam int HW = $clog2(HANDLE_COUNT);
   localparam int PW = $clog2(HEAP_DEPTH + 1);
   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int EW = TIME_BITS + HW;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_RD_LAST, S_RM_CMP, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP,
      S_PLACE, S_NOTE, S_HEAD_RD, S_FINAL
   } state_type;

   state_type       state_ff;
   logic [1:0]      func_ff;
   logic [TIME_BITS-1:0] now_ff, dl_ff, rd_dl_ff;
   logic [HW-1:0]   own_ff, pop_own_ff;
   logic [PW-1:0]   idx_ff, cnt_ff, pid_ff;   // idx is zero-based, widened
   logic            pv_ff, ovf_ff;

   logic            out_valid_ff, out_kind_ff, out_pv_ff, out_ovf_ff, out_last_ff;
   logic [HW-1:0]   out_owner_ff;
   logic [PW-1:0]   out_pos_ff, out_cnt_ff;
   logic [31:0]     out_nto_ff;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, ra, rb;
   logic [EW-1:0]   wr_data, da, db;
   logic [TIME_BITS-1:0] da_dl, db_dl;
   logic [HW-1:0]   da_own, db_own;
   logic            out_free;
   logic            out_load;
   logic [PW-1:0]   par_w, lc_w, rc_w;
   logic [TIME_BITS-1:0] diff_w;

   tmh_store #(.DEPTH(HEAP_DEPTH), .WIDTH(EW)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(ra), .rd_addr_b(rb), .rd_data_a(da), .rd_data_b(db)
   );

   assign da_dl  = da[EW-1:HW];
   assign da_own = da[HW-1:0];
   assign db_dl  = db[EW-1:HW];
   assign db_own = db[HW-1:0];
   assign out_free = !out_valid_ff || rsp_ready;
   assign par_w  = (idx_ff - PW'(1)) >> 1;
   assign lc_w   = PW'({idx_ff, 1'b0}) + PW'(1);
   assign rc_w   = PW'({idx_ff, 1'b0}) + PW'(2);
   assign diff_w = da_dl - now_ff;

   // read addresses by state; hold them while the compare state waits on the output
   always_comb begin
      ra = AW'(0);
      rb = AW'(0);
      case (state_ff)
         S_START, S_RD_LAST: begin
            ra = AW'(pid_ff - PW'(1));
            rb = AW'(cnt_ff - PW'(1));
         end
         S_UP_RD, S_UP_CMP: ra = AW'(par_w);
         S_DN_RD, S_DN_CMP: begin
            ra = AW'(lc_w);
            rb = AW'(rc_w);
         end
         default:   ra = AW'(0);
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(idx_ff);
      wr_data = {dl_ff, own_ff};
      case (state_ff)
         S_UP_CMP: if (idx_ff != '0 && dl_ff < da_dl && out_free) begin
            wr_en = 1'b1;
            wr_data = da;
         end
         S_DN_CMP: if (out_free) begin
            if (lc_w < cnt_ff) begin
               if (rc_w == cnt_ff || da_dl < db_dl) begin
                  if (dl_ff > da_dl) begin
                     wr_en = 1'b1;
                     wr_data = da;
                  end
               end else if (dl_ff > db_dl) begin
                  wr_en = 1'b1;
                  wr_data = db;
               end
            end
         end
         S_PLACE:  wr_en = out_free;
         default:  wr_en = 1'b0;
      endcase
   end

   // every slot write sends one word, as do the removal notice and the final word
   assign out_load = wr_en || (out_free && (state_ff == S_RD_LAST || state_ff == S_FINAL));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_owner = out_owner_ff;
   assign rsp_new_position = out_pos_ff;
   assign rsp_popped_valid = out_pv_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_entry_count = out_cnt_ff;
   assign rsp_time_left = out_nto_ff;
   assign rsp_last = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               func_ff <= req_func;
               dl_ff   <= req_deadline;
               own_ff  <= req_handle;
               // pop works on the root slot
               pid_ff  <= (req_func == FUNC_POP) ? PW'(1) : req_position_id;
               now_ff  <= req_now_ms;
               pv_ff   <= 1'b0;
               ovf_ff  <= 1'b0;
               pop_own_ff <= '0;
               state_ff <= S_START;
            end
            S_START: begin
               case (func_ff)
                  FUNC_ADD: if (cnt_ff == PW'(HEAP_DEPTH)) begin
                     ovf_ff <= 1'b1;
                     state_ff <= S_HEAD_RD;
                  end else begin
                     idx_ff <= cnt_ff;
                     cnt_ff <= cnt_ff + PW'(1);
                     state_ff <= S_UP_RD;
                  end
                  FUNC_REMOVE: if (pid_ff != '0 && pid_ff <= cnt_ff) begin
                     idx_ff <= pid_ff - PW'(1);
                     state_ff <= S_RD_LAST;
                  end else begin
                     state_ff <= S_HEAD_RD;
                  end
                  FUNC_POP: if (cnt_ff != '0) begin
                     idx_ff <= '0;
                     pv_ff <= 1'b1;
                     state_ff <= S_RD_LAST;
                  end else begin
                     state_ff <= S_HEAD_RD;
                  end
                  default: state_ff <= S_HEAD_RD;
               endcase
            end
            S_RD_LAST: if (out_free) begin
               // da: target slot, db: last slot; report the removed handle
               out_kind_ff  <= KIND_UPDATE;
               out_owner_ff <= da_own;
               out_pos_ff   <= '0;
               out_pv_ff <= 1'b0; out_ovf_ff <= 1'b0; out_cnt_ff <= '0;
               out_nto_ff <= '0; out_last_ff <= 1'b0;
               if (pv_ff) pop_own_ff <= da_own;
               rd_dl_ff <= da_dl;
               dl_ff  <= db_dl;
               own_ff <= db_own;
               cnt_ff <= cnt_ff - PW'(1);
               state_ff <= S_RM_CMP;
            end
            S_RM_CMP: begin
               if (idx_ff == cnt_ff) state_ff <= S_HEAD_RD;
               else if (pv_ff) state_ff <= S_DN_RD;
               else if (dl_ff < rd_dl_ff) state_ff <= S_UP_RD;
               else if (dl_ff == rd_dl_ff) state_ff <= S_PLACE;
               else state_ff <= S_DN_RD;
            end
            S_UP_RD: state_ff <= S_UP_CMP;
            S_UP_CMP: begin
               if (idx_ff != '0 && dl_ff < da_dl) begin
                  if (out_free) begin
                     out_kind_ff  <= KIND_UPDATE;
                     out_owner_ff <= da_own;
                     out_pos_ff   <= idx_ff + PW'(1);
                     out_pv_ff <= 1'b0; out_ovf_ff <= 1'b0; out_cnt_ff <= '0;
                     out_nto_ff <= '0; out_last_ff <= 1'b0;
                     idx_ff <= par_w;
                     state_ff <= S_UP_RD;
                  end
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_DN_RD: state_ff <= S_DN_CMP;
            S_DN_CMP: begin
               if (lc_w >= cnt_ff) begin
                  state_ff <= S_PLACE;
               end else if (rc_w == cnt_ff || da_dl < db_dl) begin
                  if (dl_ff <= da_dl) state_ff <= S_PLACE;
                  else if (out_free) begin
                     out_kind_ff  <= KIND_UPDATE;
                     out_owner_ff <= da_own;
                     out_pos_ff   <= idx_ff + PW'(1);
                     out_pv_ff <= 1'b0; out_ovf_ff <= 1'b0; out_cnt_ff <= '0;
                     out_nto_ff <= '0; out_last_ff <= 1'b0;
                     idx_ff <= lc_w;
                     state_ff <= S_DN_RD;
                  end
               end else begin
                  if (dl_ff <= db_dl) state_ff <= S_PLACE;
                  else if (out_free) begin
                     out_kind_ff  <= KIND_UPDATE;
                     out_owner_ff <= db_own;
                     out_pos_ff   <= idx_ff + PW'(1);
                     out_pv_ff <= 1'b0; out_ovf_ff <= 1'b0; out_cnt_ff <= '0;
                     out_nto_ff <= '0; out_last_ff <= 1'b0;
                     idx_ff <= rc_w;
                     state_ff <= S_DN_RD;
                  end
               end
            end
            S_PLACE: if (out_free) begin
               out_kind_ff  <= KIND_UPDATE;
               out_owner_ff <= own_ff;
               out_pos_ff   <= idx_ff + PW'(1);
               out_pv_ff <= 1'b0; out_ovf_ff <= 1'b0; out_cnt_ff <= '0;
               out_nto_ff <= '0; out_last_ff <= 1'b0;
               state_ff <= S_NOTE;
            end
            S_NOTE: state_ff <= S_HEAD_RD;
            S_HEAD_RD: state_ff <= S_FINAL;
            S_FINAL: if (out_free) begin
               out_kind_ff  <= KIND_FINAL;
               out_owner_ff <= pop_own_ff;
               out_pos_ff   <= '0;
               out_pv_ff    <= pv_ff;
               out_ovf_ff   <= ovf_ff;
               out_cnt_ff   <= cnt_ff;
               out_last_ff  <= 1'b1;
               if (cnt_ff == '0) out_nto_ff <= TIMEOUT_EMPTY;
               else if (da_dl <= now_ff) out_nto_ff <= '0;
               else if (diff_w > TIME_BITS'(TIMEOUT_MAX)) out_nto_ff <= TIMEOUT_MAX;
               else out_nto_ff <= 32'(diff_w);
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/tmh_store.sv]
`timescale 1ns / 1ps
module tmh_store #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 58
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

[rtl/timer_min_heap_checker.sv]
`timescale 1ns / 1ps
module timer_min_heap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic        rsp_last,
   input logic        rsp_popped_valid,
   input logic        rsp_overflow,
   input logic [8:0]  rsp_entry_count,
   input logic [31:0] rsp_time_left
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last))
      else $error("result word changed while stalled");
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == rsp_kind))
      else $error("last and kind disagree");
   a_update_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_popped_valid && !rsp_overflow)
      else $error("status flag on update word");
   a_empty_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_entry_count == 9'd0 |-> rsp_time_left == 32'hFFFF_FFFF)
      else $error("empty heap without -1 timeout");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an operation is in flight");
endmodule

bind timer_min_heap timer_min_heap_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
   .rsp_last(rsp_last), .rsp_popped_valid(rsp_popped_valid),
   .rsp_overflow(rsp_overflow), .rsp_entry_count(rsp_entry_count),
   .rsp_time_left(rsp_time_left)
);

[tb/timer_heap_checker.sv]
`timescale 1ns / 1ps
module timer_heap_checker
   import tmh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [47:0]        req_deadline,
   input  logic [9:0]         req_handle,
   input  logic [8:0]         req_position_id,
   input  logic [47:0]        req_now_ms,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_kind,
   input  logic [9:0]         rsp_owner,
   input  logic [8:0]         rsp_new_position,
   input  logic               rsp_popped_valid,
   input  logic               rsp_overflow,
   input  logic [8:0]         rsp_entry_count,
   input  logic signed [31:0] rsp_time_left,
   input  logic               rsp_last,
   output int                 error_count,
   output int                 pending_words
);
   localparam int DEPTH = 256;

   typedef struct packed {
      logic        kind;
      logic [9:0]  owner;
      logic [8:0]  new_position;
      logic        popped_valid;
      logic        overflow;
      logic [8:0]  entry_count;
      logic [31:0] time_left;
      logic        last;
   } rsp_word_type;

   logic [47:0]  heap_deadline [DEPTH];
   logic [9:0]   heap_owner [DEPTH];
   int           heap_fill;
   rsp_word_type expected_words [$];

   assign pending_words = expected_words.size();

   function automatic void add_expected(rsp_word_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void push_move(logic [9:0] owner, int pos);
      rsp_word_type w;
      w = '0;
      w.kind = KIND_UPDATE;
      w.owner = owner;
      w.new_position = pos[8:0];
      add_expected(w);
   endfunction

   function automatic void heap_raise(int idx);
      logic [47:0] d;
      logic [9:0]  o;
      int          par;
      d = heap_deadline[idx];
      o = heap_owner[idx];
      while (idx > 0) begin
         par = (idx - 1) / 2;
         if (!(d < heap_deadline[par])) break;
         heap_deadline[idx] = heap_deadline[par];
         heap_owner[idx] = heap_owner[par];
         push_move(heap_owner[idx], idx + 1);
         idx = par;
      end
      heap_deadline[idx] = d;
      heap_owner[idx] = o;
      push_move(o, idx + 1);
   endfunction

   function automatic void heap_lower(int idx);
      logic [47:0] d;
      logic [9:0]  o;
      int          child;
      d = heap_deadline[idx];
      o = heap_owner[idx];
      child = 2 * idx + 2;
      while (child <= heap_fill) begin
         if (child == heap_fill || heap_deadline[child-1] < heap_deadline[child]) child--;
         if (d <= heap_deadline[child]) break;
         heap_deadline[idx] = heap_deadline[child];
         heap_owner[idx] = heap_owner[child];
         push_move(heap_owner[idx], idx + 1);
         idx = child;
         child = 2 * idx + 2;
      end
      heap_deadline[idx] = d;
      heap_owner[idx] = o;
      push_move(o, idx + 1);
   endfunction

   function automatic void predict_op(logic [1:0] func, logic [47:0] deadline,
                                      logic [9:0] handle, logic [8:0] pid,
                                      logic [47:0] now);
      rsp_word_type fin;
      int           idx;
      int           tail;
      logic [47:0]  gone;
      logic [47:0]  diff;
      fin = '0;
      fin.kind = KIND_FINAL;
      fin.last = 1'b1;
      case (func)
         FUNC_ADD: begin
            if (heap_fill >= DEPTH) fin.overflow = 1'b1;
            else begin
               heap_deadline[heap_fill] = deadline;
               heap_owner[heap_fill] = handle;
               heap_fill++;
               heap_raise(heap_fill - 1);
            end
         end
         FUNC_REMOVE: begin
            if (pid != 0 && pid <= heap_fill) begin
               idx = pid - 1;
               tail = heap_fill - 1;
               gone = heap_deadline[idx];
               push_move(heap_owner[idx], 0);
               heap_fill--;
               if (idx != tail) begin
                  heap_deadline[idx] = heap_deadline[tail];
                  heap_owner[idx] = heap_owner[tail];
                  if (heap_deadline[idx] < gone) heap_raise(idx);
                  else if (heap_deadline[idx] == gone) push_move(heap_owner[idx], idx + 1);
                  else heap_lower(idx);
               end
            end
         end
         FUNC_POP: begin
            if (heap_fill > 0) begin
               fin.owner = heap_owner[0];
               fin.popped_valid = 1'b1;
               push_move(heap_owner[0], 0);
               heap_deadline[0] = heap_deadline[heap_fill-1];
               heap_owner[0] = heap_owner[heap_fill-1];
               heap_fill--;
               if (heap_fill > 0) heap_lower(0);
            end
         end
         default: ;
      endcase
      fin.entry_count = heap_fill[8:0];
      if (heap_fill == 0) fin.time_left = TIMEOUT_EMPTY;
      else if (heap_deadline[0] > now) begin
         diff = heap_deadline[0] - now;
         fin.time_left = (diff > 48'h7FFF_FFFF) ? TIMEOUT_MAX : diff[31:0];
      end else fin.time_left = '0;
      add_expected(fin);
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   rsp_word_type got;
   rsp_word_type want;

   always_comb begin
      got.kind = rsp_kind;
      got.owner = rsp_owner;
      got.new_position = rsp_new_position;
      got.popped_valid = rsp_popped_valid;
      got.overflow = rsp_overflow;
      got.entry_count = rsp_entry_count;
      got.time_left = rsp_time_left;
      got.last = rsp_last;
   end

   initial begin
      error_count = 0;
      heap_fill = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         heap_fill = 0;
         expected_words.delete();
      end else begin
         // check output before predicting: a fresh op cannot answer in the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) report_mismatch("unexpected word");
            else begin
               want = expected_words.pop_front();
               if (got.kind != want.kind) report_mismatch("kind");
               if (got.owner != want.owner)
                  report_mismatch($sformatf("owner %0d want %0d", got.owner, want.owner));
               if (got.new_position != want.new_position)
                  report_mismatch($sformatf("position %0d want %0d",
                                            got.new_position, want.new_position));
               if (got.popped_valid != want.popped_valid) report_mismatch("popped_valid");
               if (got.overflow != want.overflow) report_mismatch("overflow");
               if (got.entry_count != want.entry_count)
                  report_mismatch($sformatf("count %0d want %0d",
                                            got.entry_count, want.entry_count));
               if (got.time_left != want.time_left)
                  report_mismatch($sformatf("timeout %0d want %0d",
                                            $signed(got.time_left),
                                            $signed(want.time_left)));
               if (got.last != want.last) report_mismatch("last");
            end
         end
         if (req_valid && req_ready)
            predict_op(req_func, req_deadline, req_handle, req_position_id, req_now_ms);
      end
   end
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import tmh_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_func;
   logic [47:0]        req_deadline;
   logic [9:0]         req_handle;
   logic [8:0]         req_position_id;
   logic [47:0]        req_now_ms;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_kind;
   logic [9:0]         rsp_owner;
   logic [8:0]         rsp_new_position;
   logic               rsp_popped_valid;
   logic               rsp_overflow;
   logic [8:0]         rsp_entry_count;
   logic signed [31:0] rsp_time_left;
   logic               rsp_last;
   int                 error_count;
   int                 pending_words;

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off;
   int model_fill;

   timer_min_heap dut (.*);

   timer_heap_checker checker_i (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_op(logic [1:0] func, logic [47:0] deadline, logic [9:0] handle,
                          logic [8:0] pid, logic [47:0] now);
      // drop valid only when idling; otherwise the next word follows directly
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_deadline <= deadline;
      req_handle <= handle;
      req_position_id <= pid;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // rough fill tracking to steer op mix
      if (func == FUNC_ADD && model_fill < 256) model_fill++;
      else if (func == FUNC_REMOVE && pid != 0 && pid <= model_fill) model_fill--;
      else if (func == FUNC_POP && model_fill > 0) model_fill--;
   endtask

   function automatic logic [47:0] rand_time();
      case ($urandom_range(3))
         0: return 48'({$urandom, $urandom});
         1: return 48'd1000 + 48'($urandom_range(4000));
         2: return {16'd0, $urandom};
         default: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(3));
      endcase
   endfunction

   task automatic random_op();
      int r;
      r = $urandom_range(99);
      if (r < 45 && model_fill < 250 || model_fill == 0 && r < 80)
         send_op(FUNC_ADD, rand_time(), 10'($urandom), '0, rand_time());
      else if (r < 75)
         send_op(FUNC_REMOVE, '0, 10'($urandom),
                 ($urandom_range(9) == 0) ? 9'($urandom)
                    : 9'($urandom_range(model_fill > 0 ? model_fill : 1)),
                 rand_time());
      else if (r < 97) send_op(FUNC_POP, rand_time(), 10'($urandom), '0, rand_time());
      else send_op(FUNC_UNUSED, rand_time(), 10'($urandom), 9'($urandom), rand_time());
   endtask

   initial begin
      reset = 1'b1;
      hold_off = 1'b0;
      req_valid = 1'b0;
      req_func = FUNC_ADD;
      req_deadline = '0;
      req_handle = '0;
      req_position_id = '0;
      req_now_ms = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      model_fill = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, unused code, invalid removes, extremes, equal ties
      send_op(FUNC_POP, '0, '0, '0, '0);
      send_op(FUNC_UNUSED, '1, '1, '1, '1);
      send_op(FUNC_REMOVE, '0, '0, 9'd0, '0);
      send_op(FUNC_ADD, 48'hFFFF_FFFF_FFFF, 10'h3FF, '0, 48'd0);
      send_op(FUNC_ADD, 48'd0, 10'd0, '0, 48'hFFFF_FFFF_FFFF);
      send_op(FUNC_ADD, 48'd500, 10'd1, '0, 48'd100);
      send_op(FUNC_ADD, 48'd500, 10'd2, '0, 48'd600);
      send_op(FUNC_ADD, 48'd500, 10'd3, '0, 48'd0);
      send_op(FUNC_ADD, 48'd700, 10'h155, '0, 48'd0);
      send_op(FUNC_REMOVE, '0, '0, 9'd256, '0);
      send_op(FUNC_REMOVE, '0, '0, 9'd6, '0);
      send_op(FUNC_REMOVE, '0, '0, 9'd3, '0);
      send_op(FUNC_REMOVE, '0, '0, 9'd2, '0);
      send_op(FUNC_REMOVE, '0, '0, 9'd1, 48'h2AA);
      send_op(FUNC_POP, '0, '0, '0, 48'd10);
      send_op(FUNC_POP, '0, '0, '0, 48'd10);
      send_op(FUNC_POP, '0, '0, '0, 48'd10);

      // fill to capacity and overflow, with a long receiver hold-off from the start
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 257; i++)
               send_op(FUNC_ADD, rand_time(), 10'($urandom), '0, rand_time());
         end
      join
      send_op(FUNC_REMOVE, '0, '0, 9'd256, rand_time());
      for (int i = 0; i < 30; i++)
         send_op(FUNC_REMOVE, '0, '0, 9'($urandom_range(1, model_fill)), rand_time());
      while (model_fill > 200) send_op(FUNC_POP, '0, '0, '0, rand_time());

      send_idle_pct = 17;
      recv_idle_pct = 54;
      for (int i = 0; i < 50; i++) random_op();
      send_idle_pct = 54;
      recv_idle_pct = 17;
      for (int i = 0; i < 50; i++) random_op();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 50; i++) random_op();
      req_valid <= 1'b0;

      while (pending_words != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

[sim.f]
rtl/tmh_pkg.sv
rtl/tmh_store.sv
rtl/timer_min_heap.sv
rtl/timer_min_heap_checker.sv
tb/timer_heap_checker.sv
tb/testbench.sv
